// File: sv/tnon_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnon_pkg
// shared types, codes and the reply rule of the telnet option negotiator
// ----------------------------------------------------------------------------
package tnon_pkg;

	// telnet protocol bytes
	localparam logic [7:0] TN_IAC   = 8'd255;
	localparam logic [7:0] TN_WILL  = 8'd251;
	localparam logic [7:0] TN_WONT  = 8'd252;
	localparam logic [7:0] TN_DO    = 8'd253;
	localparam logic [7:0] TN_DONT  = 8'd254;
	localparam logic [7:0] TN_SGA   = 8'd3;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// result kind codes
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_REPLY = 2'd2;

	// parser phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_IAC  = 2'd1,
		PH_CMD  = 2'd2
	} phase_t;

	// one run of results caused by a single input word
	typedef struct packed {
		logic       triple;   // three-word negotiation reply
		logic [1:0] kind;     // kind of the run, sent with each of its words
		logic [7:0] byte0;    // byte of a single-word run
		logic [7:0] answer;   // second word of a reply run
		logic [7:0] option;   // third word of a reply run
		logic       prompt;   // colon seen as last non-space data byte
	} run_t;

	// answer to a negotiation command for a given option
	function automatic logic [7:0] answer_for(input logic [7:0] cmd, input logic [7:0] opt);
		logic [7:0] ans;
		if (cmd == TN_WONT) begin
			ans = TN_DONT;
		end else if (cmd == TN_DONT) begin
			ans = TN_WONT;
		end else if (opt == TN_SGA) begin
			ans = (cmd == TN_DO) ? TN_WILL : TN_DO;
		end else begin
			ans = (cmd == TN_DO) ? TN_WONT : TN_DONT;
		end
		return ans;
	endfunction

endpackage

// File: sv/telnet_option_negotiator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_negotiator
// strips telnet iac sequences from a received byte stream and answers
// option negotiation with a three-word reply run
// ----------------------------------------------------------------------------
//
// channel   dir  bits  contents
// s_axis    in   8     rx_byte
// m_axis    out  16+2  tdata: out_byte, prompt_seen; tuser: kind; tlast: last_of_run
//
// a word taken in at s_axis is held in the input register, then the
// parser turns it into a run in the result register in the same cycle the
// register frees up; one input word per cycle for data and dropped bytes while
// m_axis is ready; a negotiation triple holds the result register for three
// output words, and the input register keeps taking one more word meanwhile
// reset clears the parse state (idle, no held command, no data) and empties
// both registers; stalls on m_axis back up into s_axis_tready
//
module telnet_option_negotiator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] prompt_seen, zero fill
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last_of_run
);
	import tnon_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// handoff between input register and result register
	logic       can_load;
	logic       load;
	run_t       run;

	assign load          = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// parse state advances only when its run is committed
	tnon_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.rx_byte (byte_s1),
		.run     (run)
	);

	// result register and word sequencing
	tnon_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.run           (run),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: sv/tnon_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnon_parse
// iac sequence parser: holds the parse state and builds the result run
// ----------------------------------------------------------------------------
module tnon_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [7:0]        rx_byte,
	output tnon_pkg::run_t    run
);
	import tnon_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] held_q;
	logic [7:0] held_d;
	logic [7:0] last_ns_q;
	logic [7:0] last_ns_d;

	always_comb begin
		phase_d     = PH_IDLE;
		held_d      = held_q;
		last_ns_d   = last_ns_q;
		run.triple  = 1'b0;
		run.kind    = KIND_NONE;
		run.byte0   = 8'd0;
		run.answer  = answer_for(held_q, rx_byte);
		run.option  = rx_byte;
		unique case (phase_q)
			PH_IAC: begin
				if (rx_byte == TN_IAC) begin
					run.kind  = KIND_DATA;
					run.byte0 = rx_byte;
					last_ns_d = rx_byte;
				end else if (rx_byte == TN_WILL || rx_byte == TN_WONT ||
				             rx_byte == TN_DO || rx_byte == TN_DONT) begin
					held_d  = rx_byte;
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				run.triple = 1'b1;
				run.kind   = KIND_REPLY;
			end
			default: begin
				// idle, and the unreachable fourth code
				if (rx_byte == TN_IAC) begin
					phase_d = PH_IAC;
				end else begin
					run.kind  = KIND_DATA;
					run.byte0 = rx_byte;
					if (rx_byte != CH_SPACE) begin
						last_ns_d = rx_byte;
					end
				end
			end
		endcase
		run.prompt = (last_ns_d == CH_COLON);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			held_q    <= 8'd0;
			last_ns_q <= 8'd0;
		end else if (load) begin
			phase_q   <= phase_d;
			held_q    <= held_d;
			last_ns_q <= last_ns_d;
		end
	end

endmodule

// File: sv/tnon_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnon_emit
// result register: holds one run and sends it out one word at a time
// ----------------------------------------------------------------------------
module tnon_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tnon_pkg::run_t    run,
	output logic              can_load,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,   // [7:0] out_byte, [8] prompt_seen, zero fill
	output logic [1:0]        m_axis_tuser,   // [1:0] kind
	output logic              m_axis_tlast    // last_of_run
);
	import tnon_pkg::*;

	run_t       run_s2;
	logic       valid_s2;
	logic [1:0] idx_q;
	logic       last_word;
	logic [7:0] word_byte;
	logic       take;

	assign last_word = !run_s2.triple || (idx_q == 2'd2);
	assign take      = valid_s2 && m_axis_tready;
	assign can_load  = !valid_s2 || (take && last_word);

	always_comb begin
		case (idx_q)
			2'd0:    word_byte = run_s2.triple ? TN_IAC : run_s2.byte0;
			2'd1:    word_byte = run_s2.answer;
			default: word_byte = run_s2.option;
		endcase
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, run_s2.prompt, word_byte};
	assign m_axis_tuser  = run_s2.kind;
	assign m_axis_tlast  = last_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (take) begin
			if (last_word) begin
				valid_s2 <= 1'b0;
				idx_q    <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_s2 <= run;
		end
	end

endmodule
